FILE: src/eir_pkg.sv
// ----------------------------------------------------------------------------
// eir_pkg: shared types and constants for the local name field extractor
// Field widths, structure type codes, printable range and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package eir_pkg;

	// payload widths
	localparam int unsigned DataW = 8;
	localparam int unsigned LenW  = 16;

	// structure type codes that carry a local name
	localparam logic [DataW-1:0] TYPE_NAME_SHORT = 8'd8;
	localparam logic [DataW-1:0] TYPE_NAME_FULL  = 8'd9;

	// printable range and the characters that get replaced
	localparam logic [DataW-1:0] CHAR_PRINT_LO = 8'd32;
	localparam logic [DataW-1:0] CHAR_PRINT_HI = 8'd126;
	localparam logic [DataW-1:0] CHAR_QUOTE    = 8'd34;
	localparam logic [DataW-1:0] CHAR_BSLASH   = 8'd92;
	localparam logic [DataW-1:0] CHAR_SUBST    = 8'd63;

	// one result of the walk for one report byte
	typedef struct packed {
		logic             emit;
		logic [DataW-1:0] name_char;
		logic             name_found;
		logic             last;
	} eir_result_t;

endpackage

`default_nettype wire

FILE: src/eir_if.sv
// ----------------------------------------------------------------------------
// eir_if: valid/ready channels of the extractor
// Report byte channel and name result channel, each with source and sink.
// ----------------------------------------------------------------------------
`default_nettype none

// report bytes
interface eir_report_if;
	logic                       valid;
	logic                       ready;
	logic [eir_pkg::DataW-1:0] data_byte;
	logic                       first_byte;
	logic [eir_pkg::LenW-1:0]  report_length;

	modport source (output valid, output data_byte, output first_byte,
		output report_length, input ready);
	modport sink (input valid, input data_byte, input first_byte,
		input report_length, output ready);
endinterface

// name results
interface eir_name_if;
	logic                       valid;
	logic                       ready;
	logic [eir_pkg::DataW-1:0] name_char;
	logic                       name_found;
	logic                       last;

	modport source (output valid, output name_char, output name_found,
		output last, input ready);
	modport sink (input valid, input name_char, input name_found,
		input last, output ready);
endinterface

`default_nettype wire

FILE: src/eir_name_field_extractor_top.sv
// a report byte is held in the input register, and its result is offered from
// the result register
// throughput: one report byte per cycle while results are taken
// a stalled result register holds the walk; the input register still takes
// one more beat while it is empty
// reset: arst_n clears both valid flags and starts the walk at a new report
// ----------------------------------------------------------------------------
// eir_name_field_extractor_top: local name extractor for advertising data
// Input register, walker logic and result register; emits the sanitized
// name bytes of the first name structure or a single not-found result.
// ----------------------------------------------------------------------------
`default_nettype none

module eir_name_field_extractor_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	eir_report_if.sink  report,
	eir_name_if.source  name
);

	logic                       valid_s1;
	logic [eir_pkg::DataW-1:0] data_s1;
	logic                       first_s1;
	logic [eir_pkg::LenW-1:0]  len_s1;
	logic                       valid_s2;
	logic [eir_pkg::DataW-1:0] char_s2;
	logic                       found_s2;
	logic                       last_s2;
	logic                       s2_free;
	logic                       s1_move;
	eir_pkg::eir_result_t       res;

	// handshakes
	assign s2_free      = !valid_s2 || name.ready;
	assign s1_move      = valid_s1 && s2_free;
	assign report.ready = !valid_s1 || s2_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (report.ready) begin
			valid_s1 <= report.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (report.ready && report.valid) begin
			data_s1  <= report.data_byte;
			first_s1 <= report.first_byte;
			len_s1   <= report.report_length;
		end
	end

	eir_walk u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (s1_move),
		.data_byte     (data_s1),
		.first_byte    (first_s1),
		.report_length (len_s1),
		.result        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			char_s2  <= res.name_char;
			found_s2 <= res.name_found;
			last_s2  <= res.last;
		end
	end

	assign name.valid      = valid_s2;
	assign name.name_char  = char_s2;
	assign name.name_found = found_s2;
	assign name.last       = last_s2;

endmodule

`default_nettype wire

FILE: src/eir_walk.sv
// ----------------------------------------------------------------------------
// eir_walk: length-type-value walker
// Holds the walk state of the current report and works out the result of
// one report byte; the state advances when step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module eir_walk (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [eir_pkg::DataW-1:0] data_byte,
	input  wire logic                       first_byte,
	input  wire logic [eir_pkg::LenW-1:0]  report_length,
	output eir_pkg::eir_result_t            result
);

	typedef enum logic [2:0] {
		PH_LEN,
		PH_TYPE,
		PH_SKIP,
		PH_NAME,
		PH_DONE
	} phase_t;

	phase_t                      phase_q;
	logic [eir_pkg::LenW-1:0]   offset_q;
	logic [eir_pkg::DataW-1:0]  left_q;

	phase_t                      cur_ph;
	phase_t                      nxt_ph;
	logic [eir_pkg::LenW-1:0]   cur_off;
	logic [eir_pkg::LenW-1:0]   nxt_off;
	logic [eir_pkg::DataW-1:0]  cur_left;
	logic [eir_pkg::DataW-1:0]  nxt_left;
	logic [eir_pkg::DataW-1:0]  left_dec;
	logic [eir_pkg::LenW:0]     off_next_wide;
	logic [eir_pkg::LenW:0]     off_plus_len;
	logic                        at_end;
	logic                        overrun;
	logic                        is_name_type;
	logic                        emit;
	logic                        is_name;
	logic                        last;
	logic [eir_pkg::DataW-1:0]  clean_char;

	// a start-of-report byte restarts the walk
	always_comb begin
		if (first_byte) begin
			cur_ph   = PH_LEN;
			cur_off  = '0;
			cur_left = '0;
		end else begin
			cur_ph   = phase_q;
			cur_off  = offset_q;
			cur_left = left_q;
		end
	end

	// end-of-report and overrun checks
	assign off_next_wide = {1'b0, cur_off} + {{eir_pkg::LenW{1'b0}}, 1'b1};
	assign off_plus_len  = {1'b0, cur_off}
		+ {{(eir_pkg::LenW + 1 - eir_pkg::DataW){1'b0}}, data_byte};
	assign at_end  = off_next_wide >= {1'b0, report_length};
	assign overrun = off_plus_len >= {1'b0, report_length};
	assign is_name_type = (data_byte == eir_pkg::TYPE_NAME_SHORT)
		|| (data_byte == eir_pkg::TYPE_NAME_FULL);
	assign left_dec = (cur_left != '0) ? cur_left - 8'd1 : cur_left;

	// name character cleanup
	always_comb begin
		if (data_byte >= eir_pkg::CHAR_PRINT_LO && data_byte <= eir_pkg::CHAR_PRINT_HI
				&& data_byte != eir_pkg::CHAR_QUOTE && data_byte != eir_pkg::CHAR_BSLASH) begin
			clean_char = data_byte;
		end else begin
			clean_char = eir_pkg::CHAR_SUBST;
		end
	end

	// phase transition and result
	always_comb begin
		nxt_ph   = cur_ph;
		nxt_left = cur_left;
		emit     = 1'b0;
		is_name  = 1'b0;
		last     = 1'b0;
		unique case (cur_ph)
			PH_LEN: begin
				if (data_byte == '0 || overrun) begin
					emit   = 1'b1;
					last   = 1'b1;
					nxt_ph = PH_DONE;
				end else begin
					nxt_left = data_byte;
					nxt_ph   = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (cur_left > 8'd1 && is_name_type) begin
					nxt_left = cur_left - 8'd1;
					nxt_ph   = PH_NAME;
				end else begin
					nxt_left = left_dec;
					nxt_ph   = (left_dec != '0) ? PH_SKIP : PH_LEN;
				end
			end
			PH_SKIP: begin
				nxt_left = left_dec;
				if (left_dec == '0) begin
					nxt_ph = PH_LEN;
				end
			end
			PH_NAME: begin
				emit     = 1'b1;
				is_name  = 1'b1;
				nxt_left = left_dec;
				if (left_dec == '0) begin
					last   = 1'b1;
					nxt_ph = PH_DONE;
				end
			end
			default: begin
				nxt_ph = PH_DONE;
			end
		endcase
		// last byte of the report closes an open walk
		if (cur_ph != PH_DONE && nxt_ph != PH_DONE && at_end) begin
			emit   = 1'b1;
			last   = 1'b1;
			nxt_ph = PH_DONE;
		end
	end

	// offset saturates at its top value, frozen once the walk is done
	always_comb begin
		if (cur_ph != PH_DONE && cur_off != '1) begin
			nxt_off = off_next_wide[eir_pkg::LenW-1:0];
		end else begin
			nxt_off = cur_off;
		end
	end

	assign result.emit       = emit;
	assign result.name_char  = is_name ? clean_char : '0;
	assign result.name_found = is_name;
	assign result.last       = last;

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN;
			offset_q <= '0;
			left_q   <= '0;
		end else if (step) begin
			phase_q  <= nxt_ph;
			offset_q <= nxt_off;
			left_q   <= nxt_left;
		end
	end

endmodule

`default_nettype wire

FILE: src/eir_checker.sv
// ----------------------------------------------------------------------------
// eir_checker: port-level checks for the name extractor
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module eir_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       res_valid,
	input wire logic                       res_ready,
	input wire logic [eir_pkg::DataW-1:0] res_char,
	input wire logic                       res_found,
	input wire logic                       res_last
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_char)
			&& $stable(res_found) && $stable(res_last))
		else $error("result beat changed while stalled");

	// not-found beat is zero and closes the report
	a_notfound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_char == '0 && res_last)
		else $error("malformed not-found beat");

	// name characters are printable and never a quote or backslash
	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_found |-> res_char >= eir_pkg::CHAR_PRINT_LO
			&& res_char <= eir_pkg::CHAR_PRINT_HI && res_char != eir_pkg::CHAR_QUOTE
			&& res_char != eir_pkg::CHAR_BSLASH)
		else $error("unsanitized name character");

endmodule

bind eir_name_field_extractor_top eir_checker u_eir_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (name.valid),
	.res_ready (name.ready),
	.res_char  (name.name_char),
	.res_found (name.name_found),
	.res_last  (name.last)
);

`default_nettype wire
